### rtl/core/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared payload types, the run descriptor and the byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

	localparam int unsigned RunBytes = 6;
	localparam int unsigned RunCntW  = $clog2(RunBytes + 1);
	localparam int unsigned RunIdxW  = $clog2(RunBytes);

	localparam logic [7:0] REPL_B0   = 8'hEF;
	localparam logic [7:0] REPL_B1   = 8'hBF;
	localparam logic [7:0] REPL_B2   = 8'hBD;
	localparam logic [7:0] LEAD2     = 8'hC0;
	localparam logic [7:0] LEAD3     = 8'hE0;
	localparam logic [7:0] LEAD4     = 8'hF0;
	localparam logic [7:0] CONT      = 8'h80;
	localparam logic [5:0] HIGH_TAG  = 6'b110110;
	localparam logic [5:0] LOW_TAG   = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} u16u8_in_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last_of_run;
		logic       string_done;
	} u16u8_out_t;

	// All bytes caused by one request, ready to be sent in order.
	typedef struct packed {
		logic [RunBytes-1:0][7:0] bytes;
		logic [RunCntW-1:0]       count;
		logic                     eos;
	} u16u8_run_t;

endpackage

`default_nettype wire

### rtl/core/u16u8_encode.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder front end
// Turns one code unit into a run of up to six bytes and keeps the pending
// high surrogate between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_encode import u16u8_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire u16u8_in_t  item,
	output u16u8_run_t      run
);

	logic       pending_q;
	logic [9:0] held_q;
	logic       is_hi;
	logic       is_lo;
	logic       pair;
	logic [20:0] cp;
	logic [2:0][7:0] fresh;
	logic [1:0] fresh_cnt;

	assign is_hi = (item.code_unit[15:10] == HIGH_TAG);
	assign is_lo = (item.code_unit[15:10] == LOW_TAG);
	assign pair  = pending_q & is_lo;
	assign cp    = SUPP_BASE + {1'b0, held_q, item.code_unit[9:0]};

	// Bytes of the unit taken on its own (not as the second half of a pair).
	always_comb begin
		fresh     = '0;
		fresh_cnt = 2'd0;
		if (is_hi) begin
			if (item.end_of_string) begin
				fresh     = {REPL_B2, REPL_B1, REPL_B0};
				fresh_cnt = 2'd3;
			end
		end else if (is_lo) begin
			fresh     = {REPL_B2, REPL_B1, REPL_B0};
			fresh_cnt = 2'd3;
		end else if (item.code_unit[15:7] == '0) begin
			fresh[0]  = item.code_unit[7:0];
			fresh_cnt = 2'd1;
		end else if (item.code_unit[15:11] == '0) begin
			fresh[0]  = LEAD2 | {3'b000, item.code_unit[10:6]};
			fresh[1]  = CONT | {2'b00, item.code_unit[5:0]};
			fresh_cnt = 2'd2;
		end else begin
			fresh[0]  = LEAD3 | {4'h0, item.code_unit[15:12]};
			fresh[1]  = CONT | {2'b00, item.code_unit[11:6]};
			fresh[2]  = CONT | {2'b00, item.code_unit[5:0]};
			fresh_cnt = 2'd3;
		end
	end

	always_comb begin
		run       = '0;
		run.eos   = item.end_of_string;
		if (pair) begin
			run.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
			run.bytes[1] = CONT | {2'b00, cp[17:12]};
			run.bytes[2] = CONT | {2'b00, cp[11:6]};
			run.bytes[3] = CONT | {2'b00, cp[5:0]};
			run.count    = RunCntW'(4);
		end else if (pending_q) begin
			// The held surrogate is unpaired: replacement first, then the new unit.
			run.bytes[0] = REPL_B0;
			run.bytes[1] = REPL_B1;
			run.bytes[2] = REPL_B2;
			run.bytes[3] = fresh[0];
			run.bytes[4] = fresh[1];
			run.bytes[5] = fresh[2];
			run.count    = RunCntW'(3) + RunCntW'(fresh_cnt);
		end else begin
			run.bytes[0] = fresh[0];
			run.bytes[1] = fresh[1];
			run.bytes[2] = fresh[2];
			run.count    = RunCntW'(fresh_cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
		end else if (accept) begin
			if (!pair && is_hi && !item.end_of_string) begin
				pending_q <= 1'b1;
				held_q    <= item.code_unit[9:0];
			end else begin
				pending_q <= 1'b0;
				held_q    <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/u16u8_serial.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte serializer
// Holds one run of bytes and moves them one per cycle, while the byte channel
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_serial import u16u8_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire u16u8_run_t run_in,
	output logic            free,
	output logic            byte_valid,
	input  wire logic       byte_ready,
	output u16u8_out_t      byte_data
);

	u16u8_run_t         run_s1;
	logic               run_valid_s1;
	logic [RunIdxW-1:0] idx_q;
	logic               move;
	logic               at_end;
	u16u8_out_t         out_q;
	logic               out_valid_q;

	assign move   = run_valid_s1 && (!out_valid_q || byte_ready);
	assign at_end = (idx_q == RunIdxW'(run_s1.count - RunCntW'(1)));
	// A new run may enter as the last byte of the current one leaves.
	assign free   = !run_valid_s1 || (move && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (load) begin
			run_valid_s1 <= 1'b1;
			idx_q        <= '0;
		end else if (move) begin
			if (at_end) begin
				run_valid_s1 <= 1'b0;
				idx_q        <= '0;
			end else begin
				idx_q <= idx_q + RunIdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s1 <= run_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.byte_out    <= run_s1.bytes[idx_q];
			out_q.last_of_run <= at_end;
			out_q.string_done <= at_end && run_s1.eos;
		end
	end

	assign byte_valid = out_valid_q;
	assign byte_data  = out_q;

endmodule

`default_nettype wire

### rtl/core/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder, top level
// One UTF-16 code unit per request in, one UTF-8 byte per request out.
//
//   channel  direction  signals                               payload
//   unit     in         unit_valid, unit_ready, unit_data     u16u8_in_t
//   byte     out        byte_valid, byte_ready, byte_data     u16u8_out_t
//
// A unit is decoded in the cycle it is taken and its run of 0 to 6 bytes is
// held in a run register; the output register sends one byte per cycle while
// the byte channel is not stalled, and units that give no byte (a held high
// surrogate) are taken every cycle while the run register is empty. The next
// unit enters in the cycle the last byte of the current run moves to the
// output register. Reset clears the held surrogate and all valid flags; a
// stalled byte channel holds the output register, and the unit channel waits
// while the run register still holds bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_encoder import u16u8_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      unit_valid,
	output logic           unit_ready,
	input  wire u16u8_in_t unit_data,
	output logic           byte_valid,
	input  wire logic      byte_ready,
	output u16u8_out_t     byte_data
);

	logic       accept;
	logic       free;
	u16u8_run_t run;

	assign unit_ready = free;
	assign accept     = unit_valid && unit_ready;

	u16u8_encode u_encode (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (unit_data),
		.run    (run)
	);

	u16u8_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && (run.count != '0)),
		.run_in     (run),
		.free       (free),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data)
	);

endmodule

`default_nettype wire
